@@ hdl/nec_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the NFA epsilon-closure engine.
// No dependencies; imported by every module of the block.
package nec_pkg;

	localparam int CMD_W    = 2;
	localparam int FIELD_SW = 5;
	localparam int SYM_W    = 8;
	localparam int MASK_W   = 32;

	localparam logic [SYM_W-1:0] EPS_RESET = 8'd101;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD   = 2'd0,
		CMD_QUERY = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_Q_RUN,
		ST_Q_DONE
	} state_t;

	// Row memory controls from the sequencer.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr;
	} mem_ctl_t;

endpackage

@@ hdl/nec_row_mem.sv @@
`timescale 1ns / 1ps
// Adjacency row memory: one row of epsilon edges per state, registered read.
// Per-row valid bits give the empty-matrix view after reset or clear. Uses nec_pkg.
module nec_row_mem
	import nec_pkg::*;
#(
	parameter int NUM_STATES = 32,
	parameter int SW         = $clog2(NUM_STATES)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mem_ctl_t              ctl,
	input  logic [SW-1:0]         rd_addr,
	input  logic [SW-1:0]         wr_addr,
	input  logic [NUM_STATES-1:0] wr_data,
	output logic [NUM_STATES-1:0] rd_row
);

	logic [NUM_STATES-1:0] mem_q [NUM_STATES];
	logic [NUM_STATES-1:0] row_valid_q;
	logic [NUM_STATES-1:0] rd_data_q;
	logic                  rd_valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (ctl.clr) begin
				row_valid_q <= '0;
			end else if (ctl.wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_valid_q <= row_valid_q[rd_addr];
			end
		end
	end

	// A row never written since the last clear reads as empty.
	assign rd_row = rd_valid_q ? rd_data_q : '0;

endmodule

@@ hdl/nec_lowest.sv @@
`timescale 1ns / 1ps
// Lowest-set-bit picker: selects the next pending state to expand.
// Uses nec_pkg for the common import style only.
module nec_lowest
	import nec_pkg::*;
#(
	parameter int NUM_STATES = 32,
	parameter int SW         = $clog2(NUM_STATES)
) (
	input  logic [NUM_STATES-1:0] vec,
	output logic [NUM_STATES-1:0] pick_bit,
	output logic [SW-1:0]         pick_idx,
	output logic                  any
);

	assign pick_bit = vec & (~vec + NUM_STATES'(1));
	assign any      = |vec;

	always_comb begin
		pick_idx = '0;
		for (int i = 0; i < NUM_STATES; i++) begin
			if (pick_bit[i]) begin
				pick_idx = pick_idx | SW'(i);
			end
		end
	end

endmodule

@@ hdl/nfa_epsilon_closure.sv @@
`timescale 1ns / 1ps
// NFA epsilon-closure engine: top level with sequencer and output register.
// Depends on nec_pkg, nec_row_mem and nec_lowest.
//
// Usage:
//   Input channel (in_valid / in_stall) carries cmd, from_state, symbol, to_state.
//   add (cmd 0) stores the edge from_state -> to_state when symbol equals the
//   epsilon symbol and both states are below NUM_STATES; a stored add reads the
//   row, then writes it back. clear (cmd 2) empties the matrix; cmd 3 is dropped.
//   query (cmd 1) returns one transaction on the output channel (out_valid /
//   out_stall): closure_mask and queried_state. One row read issues per cycle
//   while states are pending, and a row returns in the cycle after its read; a
//   query of an out-of-range state does no row reads and returns an empty mask.
//   in_stall is high while a command is in progress. The result sits in an
//   output register; when the receiver stalls, the block still takes adds and
//   clears, and a following query holds its result until the register frees up.
//   cfg_valid / cfg_ready writes the epsilon symbol; cfg_ready is always high.
//   Reset empties the matrix at once (per-row valid bits) and sets the symbol to 101.
module nfa_epsilon_closure
	import nec_pkg::*;
#(
	parameter int NUM_STATES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [FIELD_SW-1:0] from_state,
	input  logic [SYM_W-1:0]    symbol,
	input  logic [FIELD_SW-1:0] to_state,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [MASK_W-1:0]   closure_mask,
	output logic [FIELD_SW-1:0] queried_state,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [SYM_W-1:0]    cfg_data
);

	localparam int SW = $clog2(NUM_STATES);
	localparam logic [6:0] NS_EXT = 7'(NUM_STATES);

	state_t state_q, state_d;

	logic [SYM_W-1:0]      eps_q;
	logic [NUM_STATES-1:0] reached_q;
	logic [NUM_STATES-1:0] pending_q;
	logic                  rd_pend_q;
	logic [SW-1:0]         row_q;
	logic [SW-1:0]         to_q;
	logic [FIELD_SW-1:0]   queried_q;
	logic                  out_valid_q;
	logic [MASK_W-1:0]     closure_q;
	logic [FIELD_SW-1:0]   out_state_q;

	logic                  in_acc;
	logic                  out_free;
	logic                  out_load;
	logic [6:0]            from_ext;
	logic [6:0]            to_ext;
	logic                  from_ok;
	logic                  add_ok;
	logic [SW-1:0]         from_idx;
	logic [SW-1:0]         to_idx;
	logic [NUM_STATES-1:0] from_bit;
	logic [NUM_STATES-1:0] rd_row;
	logic [NUM_STATES-1:0] fresh;
	logic [NUM_STATES-1:0] pick_bit;
	logic [SW-1:0]         pick_idx;
	logic                  pick_any;
	logic [MASK_W-1:0]     reached_32;
	mem_ctl_t              mem_ctl;
	logic [SW-1:0]         rd_addr;
	logic [NUM_STATES-1:0] wr_data;

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign from_ext = {2'b00, from_state};
	assign to_ext   = {2'b00, to_state};
	assign from_ok  = from_ext < NS_EXT;
	assign add_ok   = (symbol == eps_q) && from_ok && (to_ext < NS_EXT);
	assign from_idx = from_ext[SW-1:0];
	assign to_idx   = to_ext[SW-1:0];
	assign from_bit = NUM_STATES'(1) << from_idx;

	assign fresh = rd_pend_q ? (rd_row & ~reached_q) : '0;

	generate
		if (NUM_STATES >= MASK_W) begin : g_wide
			assign reached_32 = reached_q[MASK_W-1:0];
		end else begin : g_narrow
			assign reached_32 = {{(MASK_W-NUM_STATES){1'b0}}, reached_q};
		end
	endgenerate

	nec_lowest #(
		.NUM_STATES(NUM_STATES),
		.SW        (SW)
	) u_lowest (
		.vec     (pending_q),
		.pick_bit(pick_bit),
		.pick_idx(pick_idx),
		.any     (pick_any)
	);

	nec_row_mem #(
		.NUM_STATES(NUM_STATES),
		.SW        (SW)
	) u_row_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mem_ctl),
		.rd_addr(rd_addr),
		.wr_addr(row_q),
		.wr_data(wr_data),
		.rd_row (rd_row)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (cmd == CMD_ADD && add_ok) begin
						state_d = ST_ADD_RD;
					end else if (cmd == CMD_QUERY) begin
						state_d = from_ok ? ST_Q_RUN : ST_Q_DONE;
					end
				end
			end
			ST_ADD_RD: state_d = ST_ADD_WR;
			ST_ADD_WR: state_d = ST_IDLE;
			ST_Q_RUN: begin
				if (!pick_any && !rd_pend_q) begin
					state_d = ST_Q_DONE;
				end
			end
			ST_Q_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		in_stall      = 1'b1;
		mem_ctl.rd_en = 1'b0;
		mem_ctl.wr_en = 1'b0;
		mem_ctl.clr   = 1'b0;
		rd_addr       = from_idx;
		out_load      = 1'b0;
		wr_data       = rd_row | (NUM_STATES'(1) << to_q);
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && cmd == CMD_ADD && add_ok) begin
					mem_ctl.rd_en = 1'b1;
				end
				if (in_valid && cmd == CMD_CLEAR) begin
					mem_ctl.clr = 1'b1;
				end
			end
			ST_ADD_RD: begin
			end
			ST_ADD_WR: begin
				mem_ctl.wr_en = 1'b1;
			end
			ST_Q_RUN: begin
				rd_addr       = pick_idx;
				mem_ctl.rd_en = pick_any;
			end
			ST_Q_DONE: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			eps_q       <= EPS_RESET;
			reached_q   <= '0;
			pending_q   <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				eps_q <= cfg_data;
			end
			if (state_q == ST_IDLE && in_acc && cmd == CMD_QUERY) begin
				reached_q <= from_ok ? from_bit : '0;
				pending_q <= from_ok ? from_bit : '0;
				rd_pend_q <= 1'b0;
			end else if (state_q == ST_Q_RUN) begin
				// merge the row read last cycle, retire the row issued now
				reached_q <= reached_q | fresh;
				pending_q <= (pending_q & ~pick_bit) | fresh;
				rd_pend_q <= pick_any;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			row_q     <= from_idx;
			to_q      <= to_idx;
			queried_q <= from_state;
		end
		if (out_load) begin
			closure_q   <= reached_32;
			out_state_q <= queried_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign closure_mask  = closure_q;
	assign queried_state = out_state_q;

endmodule

@@ tb/sv/nfa_epsilon_closure_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for nfa_epsilon_closure: directed and random commands
// under several idle/stall mixes, checked against an in-bench closure predictor.
// Depends on nec_pkg and the nfa_epsilon_closure RTL.
module nfa_epsilon_closure_tb;
	import nec_pkg::*;

	localparam int NUM_STATES = 32;
	localparam int SETTLE_CYCLES = NUM_STATES + 8;
	localparam int CYCLE_LIMIT = 500000;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [SYM_W-1:0] SYM_E = 8'd101;

	typedef struct packed {
		logic [MASK_W-1:0]   mask;
		logic [FIELD_SW-1:0] state;
	} closure_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [CMD_W-1:0]    cmd;
	logic [FIELD_SW-1:0] from_state;
	logic [SYM_W-1:0]    symbol;
	logic [FIELD_SW-1:0] to_state;
	logic                out_valid;
	logic                out_stall;
	logic [MASK_W-1:0]   closure_mask;
	logic [FIELD_SW-1:0] queried_state;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [SYM_W-1:0]    cfg_data;

	// predictor state
	logic [MASK_W-1:0] eps_rows [NUM_STATES];
	logic [SYM_W-1:0]  eps_sym;
	closure_t          closures_due [$];

	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned mismatches;
	int unsigned cycles = 0;

	nfa_epsilon_closure #(.NUM_STATES(NUM_STATES)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.from_state   (from_state),
		.symbol       (symbol),
		.to_state     (to_state),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.closure_mask (closure_mask),
		.queried_state(queried_state),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("nfa_epsilon_closure regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Fixed-point reachability over the epsilon rows, the start state included.
	function automatic logic [MASK_W-1:0] closure_of(input logic [FIELD_SW-1:0] start);
		logic [MASK_W-1:0] reach;
		logic [MASK_W-1:0] grown;
		int                k;
		reach = '0;
		reach[start] = 1'b1;
		repeat (NUM_STATES) begin
			grown = reach;
			for (k = 0; k < NUM_STATES; k++)
				if (reach[k])
					grown |= eps_rows[k];
			reach = grown;
		end
		return reach;
	endfunction

	// Inputs are stable between edges, so a transaction seen at the falling edge
	// completes at the next rising edge.
	always @(negedge clk) begin
		closure_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (closures_due.size() == 0) begin
				$display("%0t: result expected none actual mask %h state %0d",
					$time, closure_mask, queried_state);
				mismatches++;
			end else begin
				want = closures_due.pop_front();
				if (closure_mask !== want.mask) begin
					$display("%0t: closure_mask expected %h actual %h",
						$time, want.mask, closure_mask);
					mismatches++;
				end
				if (queried_state !== want.state) begin
					$display("%0t: queried_state expected %0d actual %0d",
						$time, want.state, queried_state);
					mismatches++;
				end
			end
		end
	end

	// Called and returns at a rising edge.
	task automatic send_item(input logic [CMD_W-1:0] op, input logic [FIELD_SW-1:0] src,
		input logic [SYM_W-1:0] sym, input logic [FIELD_SW-1:0] dst);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= op;
		from_state <= src;
		symbol     <= sym;
		to_state   <= dst;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		case (op)
			CMD_ADD: if (sym == eps_sym) eps_rows[src][dst] = 1'b1;
			CMD_CLEAR: foreach (eps_rows[k]) eps_rows[k] = '0;
			CMD_QUERY: closures_due.push_back('{mask: closure_of(src), state: src});
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Adds and clears give no result, so allow the engine to finish after the last one.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (closures_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_epsilon(input logic [SYM_W-1:0] sym);
		cfg_valid <= 1'b1;
		cfg_data  <= sym;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		eps_sym = sym;
	endtask

	task automatic test_directed();
		// reset symbol is 'e'
		send_item(CMD_QUERY, 5'd0, 8'd0, 5'd0);
		send_item(CMD_ADD, 5'd0, SYM_E, 5'd1);
		send_item(CMD_ADD, 5'd1, SYM_E, 5'd2);
		send_item(CMD_ADD, 5'd2, SYM_E, 5'd0);
		send_item(CMD_ADD, 5'd0, 8'd0, 5'd31);
		send_item(CMD_ADD, 5'd0, 8'd255, 5'd31);
		send_item(CMD_ADD, 5'd0, SYM_E, 5'd1);
		send_item(CMD_QUERY, 5'd0, 8'd255, 5'd31);
		send_item(CMD_QUERY, 5'd2, 8'd0, 5'd0);
		send_item(CMD_ADD, 5'd31, SYM_E, 5'd31);
		send_item(CMD_QUERY, 5'd31, 8'd0, 5'd0);
		send_item(CMD_ADD, 5'd30, SYM_E, 5'd31);
		send_item(CMD_QUERY, 5'd30, 8'd0, 5'd0);
		send_item(CMD_UNUSED, 5'd31, 8'd255, 5'd31);
		send_item(CMD_ADD, 5'd2, SYM_E, 5'd30);
		send_item(CMD_QUERY, 5'd1, 8'd0, 5'd0);
		send_item(CMD_CLEAR, 5'd31, 8'd255, 5'd31);
		send_item(CMD_QUERY, 5'd0, 8'd0, 5'd0);
		send_item(CMD_QUERY, 5'd31, 8'd0, 5'd0);
		wait_idle();
	endtask

	task automatic test_epsilon_register();
		int k;
		write_epsilon(8'd0);
		send_item(CMD_ADD, 5'd5, SYM_E, 5'd6);
		// longest search: one chain through every state
		for (k = NUM_STATES - 1; k > 0; k--)
			send_item(CMD_ADD, 5'(k - 1), 8'd0, 5'(k));
		send_item(CMD_QUERY, 5'd0, 8'd0, 5'd0);
		send_item(CMD_QUERY, 5'd16, 8'd0, 5'd0);
		wait_idle();
		write_epsilon(8'd255);
		send_item(CMD_ADD, 5'd31, 8'd255, 5'd0);
		send_item(CMD_ADD, 5'd20, 8'd0, 5'd3);
		send_item(CMD_QUERY, 5'd31, 8'd0, 5'd0);
		send_item(CMD_QUERY, 5'd20, 8'd0, 5'd0);
		send_item(CMD_CLEAR, 5'd0, 8'd0, 5'd0);
		wait_idle();
	endtask

	task automatic send_random();
		int unsigned         pick;
		logic [FIELD_SW-1:0] src;
		logic [FIELD_SW-1:0] dst;
		pick = $urandom_range(99);
		src  = 5'($urandom_range(NUM_STATES - 1));
		// favor short hops so chains and cycles form
		dst  = pick[0] ? 5'(src + $urandom_range(2)) : 5'($urandom_range(NUM_STATES - 1));
		if (pick < 48)
			send_item(CMD_ADD, src, eps_sym, dst);
		else if (pick < 84)
			send_item(CMD_QUERY, src, 8'($urandom_range(255)), dst);
		else if (pick < 86)
			send_item(CMD_CLEAR, src, 8'($urandom_range(255)), dst);
		else if (pick < 95)
			send_item(CMD_ADD, src, 8'($urandom_range(255)), dst);
		else
			send_item(CMD_UNUSED, src, 8'($urandom_range(255)), dst);
	endtask

	task automatic test_random(input int unsigned items, input int unsigned idle,
		input int unsigned stall, input logic [SYM_W-1:0] sym);
		write_epsilon(sym);
		idle_pct  = idle;
		stall_pct = stall;
		repeat (items) send_random();
		wait_idle();
		idle_pct  = 0;
		stall_pct = 0;
	endtask

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		cmd        <= CMD_ADD;
		from_state <= '0;
		symbol     <= '0;
		to_state   <= '0;
		cfg_valid  <= 1'b0;
		cfg_data   <= '0;
		out_stall  <= 1'b0;
		mismatches = 0;
		idle_pct   = 0;
		stall_pct  = 0;
		eps_sym    = EPS_RESET;
		foreach (eps_rows[k]) eps_rows[k] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_epsilon_register();
		test_random(120, 0, 0, 8'($urandom_range(255)));
		test_random(110, 84, 0, 8'd255);
		test_random(110, 0, 84, 8'd0);
		test_random(110, 33, 33, SYM_E);

		if (mismatches == 0)
			$display("nfa_epsilon_closure regression: pass");
		else
			$display("nfa_epsilon_closure regression: fail");
		$finish;
	end

endmodule
